/* design/rmq_pkg.sv */
`default_nettype none
package rmq_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int DATA_W      = 16;
   localparam int W_W         = 15;
   localparam int ONE         = 1 << FRAC_BITS;
   localparam int LANES       = 3;
   localparam int QUEUE_DEPTH = 4;

   // one plus trace: three elements plus one, signed
   localparam int U_W    = DATA_W + 2;
   // root of (u << FRAC_BITS), one result bit per step
   localparam int RT_W   = (U_W - 1 + FRAC_BITS + 1) / 2;
   localparam int RAD_W  = 2 * RT_W;
   localparam int SREM_W = RT_W + 3;
   // divide (mag * ONE + root) by 2 * root
   localparam int MAG_W  = DATA_W;
   localparam int QB     = FRAC_BITS + 1;
   localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
   localparam int DW     = RT_W + 1;
   localparam int DREM_W = DW + 1;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
      logic [W_W-1:0]           quat_w;
      logic                     degenerate;
   } rsp_type;

   typedef struct packed {
      logic                         degenerate;
      logic [RAD_W-1:0]             radicand;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0][MAG_W-1:0]  mag;
   } job_type;

   typedef struct packed {
      logic [SREM_W-1:0] rem;
      logic [RT_W-1:0]   root;
   } sq_type;

   typedef struct packed {
      logic                         degenerate;
      logic [LANES-1:0]             neg;
      logic [RT_W-1:0]              root;
      logic [DW-1:0]                d;
      logic [LANES-1:0][NUM_W-1:0]  num;
      logic [LANES-1:0][DREM_W-1:0] rem;
      logic [LANES-1:0]             ovf;
      logic [LANES-1:0][QB-1:0]     q;
   } dv_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem;
      logic              q;
   } dstep_type;

   function automatic sq_type sq_step(input sq_type st, input logic [1:0] pair);
      logic [SREM_W-1:0] cur;
      logic [SREM_W-1:0] trial;
      sq_type            res;
      cur   = {st.rem[SREM_W-3:0], pair};
      trial = SREM_W'({st.root, 2'b01});
      if (cur >= trial) begin
         res.rem  = cur - trial;
         res.root = {st.root[RT_W-2:0], 1'b1};
      end else begin
         res.rem  = cur;
         res.root = {st.root[RT_W-2:0], 1'b0};
      end
      return res;
   endfunction

   function automatic dstep_type dv_step(input logic [DREM_W-1:0] rem, input logic [DW-1:0] d,
                                         input logic b);
      logic [DREM_W-1:0] cur;
      dstep_type         res;
      cur = {rem[DW-1:0], b};
      if (cur >= DREM_W'(d)) begin
         res.rem = cur - DREM_W'(d);
         res.q   = 1'b1;
      end else begin
         res.rem = cur;
         res.q   = 1'b0;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* design/rotation_matrix_to_quaternion.sv */
// Rotation matrix to quaternion, trace method. One matrix of nine signed Q1.14 elements is
// taken per clock and one quaternion word comes back per matrix, in order. The front
// stage forms one plus the trace and the three element differences and writes them into
// a small queue; the back pipeline takes the root one bit per stage (16 stages), divides
// the three differences by twice the root one quotient bit per stage (a set-up stage and
// 15 quotient stages) and saturates into an output register. Throughput is one matrix per
// clock while pop keeps up; the back pipeline holds as a whole whenever the output word
// is not popped, and the queue then fills up to QUEUE_DEPTH matrices before full rises.
// When one plus trace is not positive the word carries degenerate set and all
// components zero.
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
   parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic    job_valid;
   logic    job_take;
   job_type job;

   rmq_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .job_valid(job_valid),
      .job      (job),
      .job_take (job_take)
   );

   rmq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(job_valid),
      .job      (job),
      .job_take (job_take),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.degenerate) |->
         (rsp_data.quat_x == '0 && rsp_data.quat_y == '0 &&
          rsp_data.quat_z == '0 && rsp_data.quat_w == '0))
      else $error("degenerate word with nonzero components");

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.quat_w <= W_W'(ONE)))
      else $error("quat_w above one");

   a_x_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.quat_x <= DATA_W'(ONE) && rsp_data.quat_x >= -DATA_W'(ONE)))
      else $error("quat_x outside unit range");

endmodule
`default_nettype wire

/* design/rmq_front.sv */
`default_nettype none
module rmq_front import rmq_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   output logic         job_valid,
   output job_type      job,
   input  wire logic    job_take
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [U_W-1:0]    u;
   logic signed [DATA_W:0]   diff [LANES];
   logic signed [DATA_W:0]   absd [LANES];
   job_type           job_new;
   logic              wr_en, rd_en;

   // classify: form one plus trace and the three differences
   always_comb begin
      u = U_W'(ONE) + U_W'(req_data.m00) + U_W'(req_data.m11) + U_W'(req_data.m22);
      diff[0] = (DATA_W+1)'(req_data.m21) - (DATA_W+1)'(req_data.m12);
      diff[1] = (DATA_W+1)'(req_data.m02) - (DATA_W+1)'(req_data.m20);
      diff[2] = (DATA_W+1)'(req_data.m10) - (DATA_W+1)'(req_data.m01);
      job_new.degenerate = (u <= 0);
      job_new.radicand   = job_new.degenerate ? '0
                                              : RAD_W'({u[U_W-2:0], {FRAC_BITS{1'b0}}});
      for (int i = 0; i < LANES; i++) begin
         job_new.neg[i] = diff[i][DATA_W];
         absd[i]        = diff[i][DATA_W] ? -diff[i] : diff[i];
         job_new.mag[i] = absd[i][MAG_W-1:0];
      end
   end

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign job_valid = (cnt_ff != '0);
   assign job       = slot_ff[rd_ff];
   assign wr_en     = push && !full;
   assign rd_en     = job_take && job_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (wr_en) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ff] <= job_new;
      end
   end

endmodule
`default_nettype wire

/* design/rmq_back.sv */
`default_nettype none
module rmq_back import rmq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_take,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic    adv;
   logic    sq_v_ff   [1:RT_W];
   job_type sq_job_ff [1:RT_W];
   sq_type  sq_st_ff  [1:RT_W];
   logic    dv_v_ff   [0:QB];
   dv_type  dv_ff     [0:QB];
   dv_type  dv_init;
   logic    out_v_ff, out_v_in;
   rsp_type rsp_ff, rsp_in;
   logic [QB-1:0]          qsat [LANES];
   logic [DATA_W-1:0]      qval [LANES];
   logic [RT_W-2:0]        half;

   // whole back pipeline holds while the output word is not taken
   assign adv      = !out_v_ff || pop;
   assign job_take = adv;
   assign empty    = !out_v_ff;
   assign rsp_data = rsp_ff;

   for (genvar k = 1; k <= RT_W; k++) begin : g_sq
      logic    v_prev;
      job_type job_prev;
      sq_type  st_prev;
      if (k == 1) begin : g_first
         assign v_prev   = job_valid;
         assign job_prev = job;
         assign st_prev  = '0;
      end else begin : g_next
         assign v_prev   = sq_v_ff[k-1];
         assign job_prev = sq_job_ff[k-1];
         assign st_prev  = sq_st_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k] <= v_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_job_ff[k] <= job_prev;
            sq_st_ff[k]  <= sq_step(st_prev, job_prev.radicand[RAD_W-2*k +: 2]);
         end
      end
   end

   // set up numerators, divisor and the overflow check on the top bits
   always_comb begin
      dv_init            = '0;
      dv_init.degenerate = sq_job_ff[RT_W].degenerate;
      dv_init.neg        = sq_job_ff[RT_W].neg;
      dv_init.root       = sq_st_ff[RT_W].root;
      dv_init.d          = {sq_st_ff[RT_W].root, 1'b0};
      for (int i = 0; i < LANES; i++) begin
         dv_init.num[i] = NUM_W'({sq_job_ff[RT_W].mag[i], {FRAC_BITS{1'b0}}})
                          + NUM_W'(sq_st_ff[RT_W].root);
         dv_init.ovf[i] = (DW'(dv_init.num[i][NUM_W-1:QB]) >= dv_init.d);
         dv_init.rem[i] = DREM_W'(dv_init.num[i][NUM_W-1:QB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[RT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dv_init;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_dv
      dv_type    nxt;
      dstep_type st [LANES];
      always_comb begin
         nxt = dv_ff[j-1];
         for (int i = 0; i < LANES; i++) begin
            st[i]           = dv_step(dv_ff[j-1].rem[i], dv_ff[j-1].d, dv_ff[j-1].num[i][QB-j]);
            nxt.rem[i]      = st[i].rem;
            nxt.q[i][QB-j]  = st[i].q;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[j] <= nxt;
         end
      end
   end

   // saturate, restore the sign, halve the root for w; zero a degenerate word
   always_comb begin
      out_v_in = adv ? dv_v_ff[QB] : out_v_ff;
      half     = dv_ff[QB].root[RT_W-1:1];
      for (int i = 0; i < LANES; i++) begin
         qsat[i] = (dv_ff[QB].ovf[i] || dv_ff[QB].q[i] > QB'(ONE)) ? QB'(ONE)
                                                                   : dv_ff[QB].q[i];
         qval[i] = dv_ff[QB].neg[i] ? -DATA_W'(qsat[i]) : DATA_W'(qsat[i]);
      end
      rsp_in.quat_x     = qval[0];
      rsp_in.quat_y     = qval[1];
      rsp_in.quat_z     = qval[2];
      rsp_in.quat_w     = (half > (RT_W-1)'(ONE)) ? W_W'(ONE) : W_W'(half);
      rsp_in.degenerate = 1'b0;
      if (dv_ff[QB].degenerate) begin
         rsp_in            = '0;
         rsp_in.degenerate = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire
